### hdl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and helper functions for the SHA-256 digest block.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef logic [31:0] word_t;

  // Padding constants
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;
  localparam logic [5:0] LastPos = 6'd63;

  // Initial hash values
  localparam word_t HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Sequencer states
  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StPad    = 5'b00010,
    StRound  = 5'b00100,
    StUpdate = 5'b01000,
    StOut    = 5'b10000
  } seq_state_e;

  // Control toward the round unit
  typedef struct packed {
    logic load;    // copy hash words into the working variables
    logic round;   // run one compression round
    logic update;  // add working variables into the hash words
    logic rotate;  // step hash words toward word 0 for readout
    logic init;    // restore initial hash values
  } rnd_ctrl_t;

  // Control toward the block buffer / schedule
  typedef struct packed {
    logic       push;    // shift one byte into the block
    logic [7:0] data;    // byte to shift in
    logic       expand;  // advance the message schedule by one word
  } sch_ctrl_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // Round constants
  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    round_k = k;
  endfunction

endpackage

### hdl/sha256_in_if.sv
// ----------------------------------------------------------------------------
// sha256_in_if
// Input channel: one message byte or a finish marker per transfer.
// ----------------------------------------------------------------------------
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

### hdl/sha256_out_if.sv
// ----------------------------------------------------------------------------
// sha256_out_if
// Output channel: one digest word per transfer.
// ----------------------------------------------------------------------------
interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

### hdl/sha256_message_digest.sv
// ----------------------------------------------------------------------------
// sha256_message_digest
// SHA-256 over a byte stream: byte gathering, padding sequencer and one
// shared round unit that runs the 64 rounds of each block.
//
//   channel   dir   transfer carries
//   data_i    in    kind (0 byte / 1 finish), data_byte
//   digest_o  out   digest_word, word_index, last_word
//
// A data byte is taken in the idle state; the 64th byte of a block starts
// the 64 rounds and the hash add, during which data_i.ready is low.
// A finish starts the padding bytes up to the block end (one or two blocks),
// each block is compressed, then 8 digest transfers follow; the round
// unit runs one round per cycle.
// Reset loads the initial hash values and clears the byte and bit counts.
// A stall on digest_o holds the current word; no input is taken until the
// eighth word has been transferred.
// ----------------------------------------------------------------------------
module sha256_message_digest (
  input  logic          clk_i,
  input  logic          rst_ni,
  sha256_in_if.sink     data_i,
  sha256_out_if.source  digest_o
);
  import sha256_pkg::*;

  seq_state_e  state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;      // bytes in current block
  logic [63:0] bits_q, bits_d;    // message length in bits
  logic [5:0]  rnd_q, rnd_d;
  logic [2:0]  widx_q, widx_d;
  logic        first_q, first_d;  // 0x80 still to be written
  logic        len_q, len_d;      // writing the length field
  logic        fin_q, fin_d;      // padding in progress
  logic        len_cond;
  logic [7:0]  pad_byte;
  logic        in_xfer, out_xfer;
  rnd_ctrl_t   rnd_ctrl;
  sch_ctrl_t   sch_ctrl;
  word_t       w;
  word_t       hash0;

  assign data_i.ready = (state_q == StIdle);
  assign in_xfer      = data_i.valid && data_i.ready;
  assign out_xfer     = digest_o.valid && digest_o.ready;

  // Padding byte select
  assign len_cond = len_q || (!first_q && (cnt_q == LenPos));
  always_comb begin
    if (first_q) begin
      pad_byte = PadByte;
    end else if (len_cond) begin
      pad_byte = bits_q[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    bits_d   = bits_q;
    rnd_d    = rnd_q;
    widx_d   = widx_q;
    first_d  = first_q;
    len_d    = len_q;
    fin_d    = fin_q;
    rnd_ctrl = '0;
    sch_ctrl = '0;

    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (!data_i.kind) begin
            sch_ctrl.push = 1'b1;
            sch_ctrl.data = data_i.data_byte;
            cnt_d         = cnt_q + 6'd1;
            bits_d        = bits_q + 64'd8;
            if (cnt_q == LastPos) begin
              rnd_ctrl.load = 1'b1;
              rnd_d         = '0;
              state_d       = StRound;
            end
          end else begin
            fin_d   = 1'b1;
            first_d = 1'b1;
            state_d = StPad;
          end
        end
      end

      StPad: begin
        sch_ctrl.push = 1'b1;
        sch_ctrl.data = pad_byte;
        first_d       = 1'b0;
        cnt_d         = cnt_q + 6'd1;
        if (!first_q && len_cond) begin
          len_d  = 1'b1;
          bits_d = {bits_q[55:0], 8'h00};
        end
        if (cnt_q == LastPos) begin
          rnd_ctrl.load = 1'b1;
          rnd_d         = '0;
          state_d       = StRound;
        end
      end

      StRound: begin
        rnd_ctrl.round  = 1'b1;
        sch_ctrl.expand = 1'b1;
        rnd_d           = rnd_q + 6'd1;
        if (rnd_q == LastPos) begin
          state_d = StUpdate;
        end
      end

      StUpdate: begin
        rnd_ctrl.update = 1'b1;
        if (len_q) begin
          len_d   = 1'b0;
          fin_d   = 1'b0;
          widx_d  = '0;
          state_d = StOut;
        end else if (fin_q) begin
          state_d = StPad;
        end else begin
          state_d = StIdle;
        end
      end

      StOut: begin
        if (out_xfer) begin
          rnd_ctrl.rotate = 1'b1;
          widx_d          = widx_q + 3'd1;
          if (widx_q == 3'd7) begin
            rnd_ctrl.init = 1'b1;
            state_d       = StIdle;
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      bits_q  <= '0;
      rnd_q   <= '0;
      widx_q  <= '0;
      first_q <= 1'b0;
      len_q   <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bits_q  <= bits_d;
      rnd_q   <= rnd_d;
      widx_q  <= widx_d;
      first_q <= first_d;
      len_q   <= len_d;
      fin_q   <= fin_d;
    end
  end

  // Block buffer and message schedule
  sha256_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sch_ctrl),
    .w_o    (w)
  );

  // Shared round unit and hash words
  sha256_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (rnd_ctrl),
    .rnd_i   (rnd_q),
    .w_i     (w),
    .hash0_o (hash0)
  );

  // Digest readout
  assign digest_o.valid       = (state_q == StOut);
  assign digest_o.digest_word = hash0;
  assign digest_o.word_index  = widx_q;
  assign digest_o.last_word   = (widx_q == 3'd7);

endmodule

### hdl/sha256_sched.sv
// ----------------------------------------------------------------------------
// sha256_sched
// 512-bit block buffer. Bytes shift in at the tail; during compression the
// same register serves as the 16-word message schedule window.
// ----------------------------------------------------------------------------
module sha256_sched (
  input  logic                  clk_i,
  input  sha256_pkg::sch_ctrl_t ctrl_i,
  output sha256_pkg::word_t     w_o
);
  import sha256_pkg::*;

  logic [511:0] blk_q, blk_d;
  word_t        w0, w1, w9, w14, s0, s1, w_new;

  // Window taps: word j sits at bits [511-32j -: 32]
  assign w0  = blk_q[511:480];
  assign w1  = blk_q[479:448];
  assign w9  = blk_q[223:192];
  assign w14 = blk_q[63:32];

  // Schedule expansion
  assign s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign w_new = s1 + w9 + s0 + w0;

  always_comb begin
    blk_d = blk_q;
    if (ctrl_i.push) begin
      blk_d = {blk_q[503:0], ctrl_i.data};
    end else if (ctrl_i.expand) begin
      blk_d = {blk_q[479:0], w_new};
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
  end

  assign w_o = w0;

endmodule

### hdl/sha256_round.sv
// ----------------------------------------------------------------------------
// sha256_round
// Shared compression round unit: working variables, one round per cycle,
// and the eight hash words with final add and word-by-word readout.
// ----------------------------------------------------------------------------
module sha256_round (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sha256_pkg::rnd_ctrl_t ctrl_i,
  input  logic [5:0]            rnd_i,
  input  sha256_pkg::word_t     w_i,
  output sha256_pkg::word_t     hash0_o
);
  import sha256_pkg::*;

  word_t v_q [8];
  word_t v_d [8];
  word_t hash_q [8];
  word_t hash_d [8];
  word_t big0, big1, ch, maj, t1, t2;

  // Round function
  assign big1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
  assign ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1   = v_q[7] + big1 + ch + round_k(rnd_i) + w_i;
  assign big0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
  assign maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2   = big0 + maj;

  // Working variables
  always_comb begin
    v_d = v_q;
    if (ctrl_i.load) begin
      v_d = hash_q;
    end else if (ctrl_i.round) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  // Hash words: init wins over readout rotation
  always_comb begin
    hash_d = hash_q;
    if (ctrl_i.init) begin
      hash_d = HashInit;
    end else if (ctrl_i.update) begin
      for (int i = 0; i < 8; i++) begin
        hash_d[i] = hash_q[i] + v_q[i];
      end
    end else if (ctrl_i.rotate) begin
      for (int i = 0; i < 7; i++) begin
        hash_d[i] = hash_q[i+1];
      end
      hash_d[7] = hash_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= HashInit;
    end else begin
      hash_q <= hash_d;
    end
  end

  assign hash0_o = hash_q[0];

endmodule

### verif/sha256_tb_pkg.sv
// ----------------------------------------------------------------------------
// sha256_tb_pkg
// Item codes shared by the SHA-256 digest testbench and its checker.
// ----------------------------------------------------------------------------
package sha256_tb_pkg;

  // Meaning of the kind field of an input transfer
  typedef enum logic {
    KindByte   = 1'b0,
    KindFinish = 1'b1
  } item_kind_e;

endpackage

### verif/sha256_digest_checker.sv
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches both channels of the digest block, keeps its own SHA-256 state,
// queues the eight digest words of every finished message and compares each
// output transfer against the oldest queued word.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        in_kind_i,
  input  logic [7:0]  in_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] out_word_i,
  input  logic [2:0]  out_index_i,
  input  logic        out_last_i,
  output int          mismatch_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sha256_tb_pkg::*;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] IvWords [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] KWords [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Predicted hashing state
  logic [31:0] chain_words [8];
  logic [7:0]  block_buf [64];
  logic [5:0]  block_fill;
  logic [63:0] msg_bit_len;

  digest_word_t digest_q [$];
  int fail_count = 0;
  int pending    = 0;

  assign mismatch_count_o = fail_count;
  assign pending_o        = pending;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  // One 64-round compression of block_buf into chain_words
  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    {a, b, c, d, e, f, g, h} = {chain_words[0], chain_words[1], chain_words[2],
                                chain_words[3], chain_words[4], chain_words[5],
                                chain_words[6], chain_words[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
           + KWords[i] + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g;
      g = f;
      f = e;
      e = d + t1;
      d = c;
      c = b;
      b = a;
      a = t1 + t2;
    end
    chain_words[0] += a;
    chain_words[1] += b;
    chain_words[2] += c;
    chain_words[3] += d;
    chain_words[4] += e;
    chain_words[5] += f;
    chain_words[6] += g;
    chain_words[7] += h;
  endtask

  task automatic start_message();
    for (int i = 0; i < 8; i++) chain_words[i] = IvWords[i];
    block_fill  = '0;
    msg_bit_len = '0;
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    block_buf[block_fill] = b;
    msg_bit_len += 64'd8;
    block_fill++;
    if (block_fill == '0) compress_block();
  endtask

  // Pad, append the bit length, compress and queue the eight digest words
  task automatic finish_message();
    int pos;
    digest_word_t dw;
    pos = int'(block_fill);
    block_buf[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        block_buf[pos] = 8'h00;
        pos++;
      end
      compress_block();
      pos = 0;
    end
    while (pos < 56) begin
      block_buf[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++) block_buf[63-i] = msg_bit_len[8*i +: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      dw.word  = chain_words[i];
      dw.index = 3'(i);
      dw.last  = (i == 7);
      digest_q.push_back(dw);
    end
    start_message();
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic check_word();
    digest_word_t want;
    if (digest_q.size() == 0) begin
      report_mismatch("digest word with nothing pending", out_word_i, '0);
    end else begin
      want = digest_q.pop_front();
      if (out_word_i !== want.word)
        report_mismatch("digest_word", out_word_i, want.word);
      if (out_index_i !== want.index)
        report_mismatch("word_index", 32'(out_index_i), 32'(want.index));
      if (out_last_i !== want.last)
        report_mismatch("last_word", 32'(out_last_i), 32'(want.last));
    end
  endtask

  // Sample both channels on the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_message();
      digest_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_word();
      if (in_valid_i && in_ready_i) begin
        if (item_kind_e'(in_kind_i) == KindFinish) finish_message();
        else absorb_byte(in_byte_i);
      end
    end
    pending = digest_q.size();
  end

endmodule

### verif/tb_sha256_message_digest.sv
// ----------------------------------------------------------------------------
// tb_sha256_message_digest
// Feeds byte streams and finish markers into the SHA-256 digest block with
// bursty input and a stalling output; a checker beside the block predicts
// and compares every digest word.
// ----------------------------------------------------------------------------
module tb_sha256_message_digest;
  timeunit 1ns;
  timeprecision 1ps;
  import sha256_tb_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   mismatches;
  int   words_pending;
  int   burst_left;
  int   items_sent;

  sha256_in_if  data_if ();
  sha256_out_if digest_if ();

  sha256_message_digest uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .data_i   (data_if),
    .digest_o (digest_if)
  );

  sha256_digest_checker checker_u (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (data_if.valid),
    .in_ready_i       (data_if.ready),
    .in_kind_i        (data_if.kind),
    .in_byte_i        (data_if.data_byte),
    .out_valid_i      (digest_if.valid),
    .out_ready_i      (digest_if.ready),
    .out_word_i       (digest_if.digest_word),
    .out_index_i      (digest_if.word_index),
    .out_last_i       (digest_if.last_word),
    .mismatch_count_o (mismatches),
    .pending_o        (words_pending)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Output stalls: switch between free flow, half rate and heavy stall
  int stall_mode;
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(10, 60);
    end
    stall_left--;
    case (stall_mode)
      0: digest_if.ready <= 1'b1;
      1: digest_if.ready <= 1'($urandom_range(0, 1));
      default: digest_if.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // One input transfer; a burst may end in a random gap with valid low
  task automatic send_item(input item_kind_e k, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        data_if.valid     <= 1'b0;
        data_if.kind      <= 1'($urandom_range(0, 1));
        data_if.data_byte <= 8'($urandom_range(0, 255));
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 24);
    end
    @(negedge clk_i);
    data_if.valid     <= 1'b1;
    data_if.kind      <= k;
    data_if.data_byte <= b;
    do @(posedge clk_i); while (!data_if.ready);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_message(input int len, input int fill_mode);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (fill_mode)
        0: b = 8'h00;
        1: b = 8'hff;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_item(KindByte, b);
    end
    send_item(KindFinish, 8'($urandom_range(0, 255)));
  endtask

  int msg_len;

  initial begin
    data_if.valid     = 1'b0;
    data_if.kind      = KindByte;
    data_if.data_byte = '0;
    burst_left        = 0;
    items_sent        = 0;
    rst_ni            = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty message, single extreme bytes, "abc", back-to-back finish
    send_item(KindFinish, 8'h00);
    send_item(KindByte, 8'h00);
    send_item(KindFinish, 8'hff);
    send_item(KindByte, 8'hff);
    send_item(KindFinish, 8'h00);
    send_item(KindByte, 8'h61);
    send_item(KindByte, 8'h62);
    send_item(KindByte, 8'h63);
    send_item(KindFinish, 8'h55);
    send_item(KindFinish, 8'haa);
    send_item(KindFinish, 8'h01);
    send_item(KindByte, 8'h80);
    send_item(KindByte, 8'h7f);
    send_item(KindByte, 8'h55);
    send_item(KindByte, 8'haa);
    send_item(KindFinish, 8'hfe);

    // Random messages, lengths weighted toward the padding boundaries
    while (items_sent < 390) begin
      case ($urandom_range(0, 9))
        0: msg_len = $urandom_range(55, 57);
        1: msg_len = $urandom_range(62, 65);
        2: msg_len = $urandom_range(119, 121);
        3: msg_len = $urandom_range(0, 3);
        4: msg_len = $urandom_range(58, 61);
        default: msg_len = $urandom_range(4, 130);
      endcase
      send_message(msg_len, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : 2);
    end

    @(negedge clk_i);
    data_if.valid <= 1'b0;
    while (words_pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("sha256_message_digest test passed");
    end else begin
      $display("sha256_message_digest test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("sha256_message_digest test failed");
    $finish;
  end

endmodule
